// ===== hdl/hbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the heightmap bilinear sampler.
// No dependencies; hbs_ram aside, all other files use this package.
package hbs_pkg;

  localparam int ADDR_W  = 12;  // sample store address bits
  localparam int SIDE_W  = 7;   // grid side register bits
  localparam int COORD_W = 6;   // clamped corner coordinate bits
  localparam int CFG_IDX_W = 2;

  localparam logic [SIDE_W-1:0] SIDE_MIN = 7'd2;
  localparam logic [SIDE_W-1:0] SIDE_MAX = 7'd64;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_GAIN    = 2'd3;

  localparam logic [23:0] INV_SCALE_RESET = 24'd65536;
  localparam logic [23:0] VERT_GAIN_RESET = 24'd257;

  typedef struct packed {
    logic               operation;
    logic [11:0]        sample_index;
    logic [7:0]         sample_value;
    logic signed [23:0] query_x;
    logic signed [23:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] height;
    logic        in_range;
  } out_item_t;

  // Grid geometry as used by the address path (sides already saturated)
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] rows;
    logic [23:0]       inv_scale;
  } grid_cfg_t;

  // Front-end result: one item after range check and corner clamping
  typedef struct packed {
    logic               valid;
    logic               operation;
    logic               hit;
    logic [ADDR_W-1:0]  sample_index;
    logic [7:0]         sample_value;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [7:0]         fx;
    logic [7:0]         fy;
  } front_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    begin
      r = s;
      if (s < SIDE_MIN) r = SIDE_MIN;
      if (s > SIDE_MAX) r = SIDE_MAX;
      return r;
    end
  endfunction

endpackage

// ===== hdl/hbs_ram.sv =====
`timescale 1ns / 1ps
// Generic synchronous RAM: one write port, two registered read ports.
// No package dependencies.
module hbs_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hdl/hbs_front.sv =====
`timescale 1ns / 1ps
// Front end: input capture, position scaling, range check and corner clamp.
// Depends on hbs_pkg.
module hbs_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  hbs_pkg::in_item_t   in_data,
  input  hbs_pkg::grid_cfg_t  cfg,
  output hbs_pkg::front_t     front
);

  // stage 1: captured item
  logic              valid1;
  hbs_pkg::in_item_t item1;

  // stage 2: scaled coordinates
  logic        valid2;
  logic        op2;
  logic        neg2;
  logic [11:0] idx2;
  logic [7:0]  val2;
  logic [46:0] u2;
  logic [46:0] v2;

  logic [46:0] u_prod;
  logic [46:0] v_prod;

  logic [30:0]                 lim_w;
  logic [30:0]                 lim_h;
  logic                        in_grid;
  logic [hbs_pkg::SIDE_W-1:0]  cx;
  logic [hbs_pkg::SIDE_W-1:0]  cy;
  logic [hbs_pkg::SIDE_W-1:0]  cx1;
  logic [hbs_pkg::SIDE_W-1:0]  cy1;
  logic [hbs_pkg::SIDE_W-1:0]  wm1;
  logic [hbs_pkg::SIDE_W-1:0]  hm1;
  logic [hbs_pkg::SIDE_W-1:0]  x0_c;
  logic [hbs_pkg::SIDE_W-1:0]  x1_c;
  logic [hbs_pkg::SIDE_W-1:0]  y0_c;
  logic [hbs_pkg::SIDE_W-1:0]  y1_c;

  always_comb begin
    u_prod = 47'(item1.query_x[22:0]) * 47'(cfg.inv_scale);
    v_prod = 47'(item1.query_y[22:0]) * 47'(cfg.inv_scale);
  end

  always_comb begin
    lim_w   = {cfg.width, 24'd0};
    lim_h   = {cfg.rows, 24'd0};
    in_grid = (u2 <= 47'(lim_w)) && (v2 <= 47'(lim_h));
    // inside the grid the cell index is at most the side, so 7 bits hold it
    cx   = u2[30:24];
    cy   = v2[30:24];
    cx1  = cx + 7'd1;
    cy1  = cy + 7'd1;
    wm1  = cfg.width - 7'd1;
    hm1  = cfg.rows - 7'd1;
    x0_c = (cx  < wm1) ? cx  : wm1;
    x1_c = (cx1 < wm1) ? cx1 : wm1;
    y0_c = (cy  < hm1) ? cy  : hm1;
    y1_c = (cy1 < hm1) ? cy1 : hm1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1      <= 1'b0;
      valid2      <= 1'b0;
      front.valid <= 1'b0;
    end else if (adv) begin
      valid1      <= in_valid;
      valid2      <= valid1;
      front.valid <= valid2;

      item1 <= in_data;

      op2  <= item1.operation;
      neg2 <= item1.query_x[23] | item1.query_y[23];
      idx2 <= item1.sample_index;
      val2 <= item1.sample_value;
      u2   <= u_prod;
      v2   <= v_prod;

      front.operation    <= op2;
      front.hit          <= (op2 == hbs_pkg::OP_QUERY) && !neg2 && in_grid;
      front.sample_index <= idx2;
      front.sample_value <= val2;
      front.x0           <= x0_c[hbs_pkg::COORD_W-1:0];
      front.x1           <= x1_c[hbs_pkg::COORD_W-1:0];
      front.y0           <= y0_c[hbs_pkg::COORD_W-1:0];
      front.y1           <= y1_c[hbs_pkg::COORD_W-1:0];
      front.fx           <= u2[23:16];
      front.fy           <= v2[23:16];
    end
  end

endmodule

// ===== hdl/hbs_blend.sv =====
`timescale 1ns / 1ps
// Back end: corner weights, bilinear blend, vertical gain and output register.
// Depends on hbs_pkg; takes samples registered by the two store copies.
module hbs_blend (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  hbs_pkg::front_t    front,
  input  logic [7:0]         s00,
  input  logic [7:0]         s01,
  input  logic [7:0]         s10,
  input  logic [7:0]         s11,
  input  logic [23:0]        gain,
  output logic               out_valid,
  output hbs_pkg::out_item_t out_data
);

  // stage 4: aligned with the store read data
  logic       valid4;
  logic       hit4;
  logic [7:0] fx4;
  logic [7:0] fy4;

  // stage 5: weights and samples
  logic        valid5;
  logic        hit5;
  logic [16:0] w00;
  logic [16:0] w01;
  logic [16:0] w10;
  logic [16:0] w11;
  logic [7:0]  t00;
  logic [7:0]  t01;
  logic [7:0]  t10;
  logic [7:0]  t11;

  // stage 6: blended sample, Q8.16
  logic        valid6;
  logic        hit6;
  logic [23:0] blend6;

  logic [8:0]  wx0;
  logic [8:0]  wx1;
  logic [8:0]  wy0;
  logic [8:0]  wy1;
  logic [17:0] p00;
  logic [17:0] p01;
  logic [17:0] p10;
  logic [17:0] p11;
  logic [24:0] blend_sum;
  logic [47:0] scaled;

  always_comb begin
    wx0 = 9'd256 - {1'b0, fx4};
    wx1 = {1'b0, fx4};
    wy0 = 9'd256 - {1'b0, fy4};
    wy1 = {1'b0, fy4};
    p00 = 18'(wx0) * 18'(wy0);
    p01 = 18'(wx1) * 18'(wy0);
    p10 = 18'(wx0) * 18'(wy1);
    p11 = 18'(wx1) * 18'(wy1);
  end

  always_comb begin
    blend_sum = 25'(w00) * 25'(t00) + 25'(w01) * 25'(t01)
              + 25'(w10) * 25'(t10) + 25'(w11) * 25'(t11);
    // blend stays below 2^24 and gain below 2^24, so no saturation is reachable
    scaled    = 48'(blend6) * 48'(gain);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4    <= 1'b0;
      valid5    <= 1'b0;
      valid6    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      valid4    <= front.valid;
      valid5    <= valid4;
      valid6    <= valid5;
      out_valid <= valid6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit4 <= front.hit;
      fx4  <= front.fx;
      fy4  <= front.fy;

      hit5 <= hit4;
      w00  <= p00[16:0];
      w01  <= p01[16:0];
      w10  <= p10[16:0];
      w11  <= p11[16:0];
      t00  <= s00;
      t01  <= s01;
      t10  <= s10;
      t11  <= s11;

      hit6   <= hit5;
      blend6 <= blend_sum[23:0];

      out_data.height   <= hit6 ? scaled[47:16] : 32'd0;
      out_data.in_range <= hit6;
    end
  end

endmodule

// ===== hdl/heightmap_bilinear_sampler_top.sv =====
`timescale 1ns / 1ps
// Heightmap bilinear sampler: front end, store read, weights, blend, output register.
// Throughput one item per cycle while no result is held; two store copies with two
// read ports each deliver all four cell corners together; loads write both copies.
// The whole pipeline advances together and holds while a result waits.
// Reset clears pipeline valids and config to defaults; the store is not cleared.
module heightmap_bilinear_sampler_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hbs_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hbs_pkg::out_item_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data
);

  hbs_pkg::grid_cfg_t cfg;
  logic [23:0]        gain;
  logic               adv;
  hbs_pkg::front_t    front;

  logic [12:0]                row0;
  logic [12:0]                row1;
  logic [hbs_pkg::ADDR_W-1:0] a00;
  logic [hbs_pkg::ADDR_W-1:0] a01;
  logic [hbs_pkg::ADDR_W-1:0] a10;
  logic [hbs_pkg::ADDR_W-1:0] a11;
  logic                       store_we;
  logic [7:0]                 s00;
  logic [7:0]                 s01;
  logic [7:0]                 s10;
  logic [7:0]                 s11;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // keep grid sides saturated at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width     <= hbs_pkg::SIDE_MAX;
      cfg.rows      <= hbs_pkg::SIDE_MAX;
      cfg.inv_scale <= hbs_pkg::INV_SCALE_RESET;
      gain          <= hbs_pkg::VERT_GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        hbs_pkg::CFG_GRID_WIDTH:  cfg.width     <= hbs_pkg::clamp_side(cfg_data[6:0]);
        hbs_pkg::CFG_GRID_HEIGHT: cfg.rows      <= hbs_pkg::clamp_side(cfg_data[6:0]);
        hbs_pkg::CFG_INV_SCALE:   cfg.inv_scale <= cfg_data[23:0];
        hbs_pkg::CFG_VERT_GAIN:   gain          <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  hbs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .front    (front)
  );

  // corner addresses; clamped corners stay below width * rows
  always_comb begin
    row0 = 13'(front.y0) * 13'(cfg.width);
    row1 = 13'(front.y1) * 13'(cfg.width);
    a00  = row0[11:0] + 12'(front.x0);
    a01  = row0[11:0] + 12'(front.x1);
    a10  = row1[11:0] + 12'(front.x0);
    a11  = row1[11:0] + 12'(front.x1);
  end

  // loads write in the read stage, so a following query sees the new sample
  assign store_we = adv && front.valid && (front.operation == hbs_pkg::OP_LOAD);

  hbs_ram #(
    .ADDR_W (hbs_pkg::ADDR_W),
    .DATA_W (8)
  ) u_ram_top (
    .clk     (clk),
    .en      (adv),
    .we      (store_we),
    .waddr   (front.sample_index),
    .wdata   (front.sample_value),
    .raddr_a (a00),
    .raddr_b (a01),
    .rdata_a (s00),
    .rdata_b (s01)
  );

  hbs_ram #(
    .ADDR_W (hbs_pkg::ADDR_W),
    .DATA_W (8)
  ) u_ram_bot (
    .clk     (clk),
    .en      (adv),
    .we      (store_we),
    .waddr   (front.sample_index),
    .wdata   (front.sample_value),
    .raddr_a (a10),
    .raddr_b (a11),
    .rdata_a (s10),
    .rdata_b (s11)
  );

  hbs_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .front     (front),
    .s00       (s00),
    .s01       (s01),
    .s10       (s10),
    .s11       (s11),
    .gain      (gain),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== test/heightmap_sample_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the heightmap bilinear sampler: tracks loads and register writes,
// predicts every result and compares it with what the block returns.
// Depends on hbs_pkg for the channel structs, opcodes and register indexes.
module heightmap_sample_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  hbs_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  hbs_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fails,
  output int                            pending,
  output int                            checked,
  output int                            hits
);
  import hbs_pkg::*;

  logic [7:0]  samples [0:4095];
  logic [6:0]  width_reg = 7'd64;
  logic [6:0]  rows_reg  = 7'd64;
  logic [23:0] inv_scale = INV_SCALE_RESET;
  logic [23:0] gain      = VERT_GAIN_RESET;
  out_item_t   heights_due[$];
  int          n_fail    = 0;
  int          n_checked = 0;
  int          n_hits    = 0;

  function automatic bit [63:0] usable_side(input logic [6:0] s);
    if (s < SIDE_MIN) return 64'(SIDE_MIN);
    if (s > SIDE_MAX) return 64'(SIDE_MAX);
    return 64'(s);
  endfunction

  function automatic bit [63:0] stored(input bit [63:0] idx);
    if (idx >= 64'd4096) return 64'd0;
    return 64'(samples[idx[11:0]]);
  endfunction

  function automatic out_item_t predict_height(input in_item_t it);
    out_item_t r;
    bit [63:0] w, h, u, v, cx, cy, fx, fy, x0, x1, y0, y1, blend, prod;
    r = '0;
    // loads and negative coordinates answer zero, out of range
    if (it.operation == OP_LOAD || it.query_x[23] || it.query_y[23]) return r;
    w = usable_side(width_reg);
    h = usable_side(rows_reg);
    u = {40'd0, it.query_x} * {40'd0, inv_scale};
    v = {40'd0, it.query_y} * {40'd0, inv_scale};
    if (u > (w << 24) || v > (h << 24)) return r;
    cx = u >> 24;
    cy = v >> 24;
    fx = (u >> 16) & 64'hFF;
    fy = (v >> 16) & 64'hFF;
    // clamp the neighbour onto the last row/column at the far edge
    x0 = (cx < w - 1) ? cx : w - 1;
    x1 = (cx + 1 < w - 1) ? cx + 1 : w - 1;
    y0 = (cy < h - 1) ? cy : h - 1;
    y1 = (cy + 1 < h - 1) ? cy + 1 : h - 1;
    blend = (64'd256 - fx) * (64'd256 - fy) * stored(y0 * w + x0)
          + fx * (64'd256 - fy) * stored(y0 * w + x1)
          + (64'd256 - fx) * fy * stored(y1 * w + x0)
          + fx * fy * stored(y1 * w + x1);
    prod = (blend * {40'd0, gain}) >> 16;
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    r.height   = prod[31:0];
    r.in_range = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  width_reg = cfg_data[6:0];
          CFG_GRID_HEIGHT: rows_reg  = cfg_data[6:0];
          CFG_INV_SCALE:   inv_scale = cfg_data[23:0];
          CFG_VERT_GAIN:   gain      = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        heights_due.push_back(predict_height(in_data));
        if (in_data.operation == OP_LOAD) samples[in_data.sample_index] = in_data.sample_value;
      end
      if (out_valid && out_ready) begin
        if (heights_due.size() == 0) begin
          $error("result transaction with nothing outstanding: height %0d in_range %0b",
                 out_data.height, out_data.in_range);
          n_fail++;
        end else begin
          want = heights_due.pop_front();
          n_checked++;
          if (want.in_range) n_hits++;
          if (out_data.height !== want.height) begin
            $error("height: expected %0d, actual %0d", want.height, out_data.height);
            n_fail++;
          end
          if (out_data.in_range !== want.in_range) begin
            $error("in_range: expected %0b, actual %0b", want.in_range, out_data.in_range);
            n_fail++;
          end
        end
      end
    end
    fails   <= n_fail;
    pending <= heights_due.size();
    checked <= n_checked;
    hits    <= n_hits;
  end

endmodule

// ===== test/tb_heightmap_bilinear_sampler_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the heightmap bilinear sampler: drives loads, queries and
// register writes with random idling; needs hbs_pkg, the block and the checker.
module tb_heightmap_bilinear_sampler_top;
  import hbs_pkg::*;

  // samples loaded up front; each programmed grid keeps width * rows within this
  localparam int FILL_SAMPLES = 256;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_WIDTH;
  logic [31:0]          cfg_data  = '0;
  logic                 in_ready, out_valid, cfg_ready;
  out_item_t            out_data;
  int                   fails, pending, checked, hits;

  // stimulus-side view of the grid, used only to aim queries inside it
  logic [6:0]  cur_w     = 7'd64;
  logic [6:0]  cur_h     = 7'd64;
  logic [23:0] cur_scale = INV_SCALE_RESET;
  int          settings  = 1;
  int          calm_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  heightmap_bilinear_sampler_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  heightmap_sample_checker scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .checked(checked), .hits(hits)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // side length the block actually uses for a register value
  function automatic int side_of(input logic [6:0] side_reg);
    if (side_reg < SIDE_MIN) return int'(SIDE_MIN);
    if (side_reg > SIDE_MAX) return int'(SIDE_MAX);
    return int'(side_reg);
  endfunction

  function automatic in_item_t load_item(input logic [11:0] idx, input logic [7:0] val);
    in_item_t it;
    it.operation    = OP_LOAD;
    it.sample_index = idx;
    it.sample_value = val;
    it.query_x      = 24'($urandom);
    it.query_y      = 24'($urandom);
    return it;
  endfunction

  function automatic in_item_t query_item(input logic [23:0] qx, input logic [23:0] qy);
    in_item_t it;
    it.operation    = OP_QUERY;
    it.sample_index = 12'($urandom);
    it.sample_value = 8'($urandom);
    it.query_x      = qx;
    it.query_y      = qy;
    return it;
  endfunction

  // Non-negative coordinate aimed at the grid: mostly inside, sometimes on
  // or just past the far edge.
  function automatic logic [23:0] in_grid_coord(input logic [6:0] side_reg,
                                                input logic [23:0] scale);
    bit [63:0] span, lim;
    int        r;
    span = 64'((side_reg < SIDE_MIN) ? SIDE_MIN : (side_reg > SIDE_MAX) ? SIDE_MAX : side_reg);
    span = span << 24;
    lim  = (scale == 24'd0) ? 64'd8388607 : span / {40'd0, scale};
    if (lim > 64'd8388607) lim = 64'd8388607;
    r = $urandom_range(0, 99);
    if (r < 6) return lim[23:0];
    if (r < 10) return (lim < 64'd8388607) ? lim[23:0] + 24'd1 : lim[23:0];
    if (r < 14) return 24'd0;
    return 24'($urandom_range(0, lim[31:0]));
  endfunction

  function automatic in_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return load_item(12'($urandom), 8'($urandom));
    if (r < 30) return query_item(24'($urandom), 24'($urandom));
    if (r < 35) return query_item(in_grid_coord(cur_w, cur_scale), 24'($urandom));
    if (r < 40) return query_item(24'($urandom), in_grid_coord(cur_h, cur_scale));
    return query_item(in_grid_coord(cur_w, cur_scale), in_grid_coord(cur_h, cur_scale));
  endfunction

  task automatic push_item(input in_item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Fill the bits above each field with junk; the block keeps only the field.
  task automatic program_grid(input logic [6:0] w, input logic [6:0] h,
                              input logic [23:0] scale, input logic [23:0] g);
    write_reg(CFG_GRID_WIDTH,  {25'($urandom), w});
    write_reg(CFG_GRID_HEIGHT, {25'($urandom), h});
    write_reg(CFG_INV_SCALE,   {8'($urandom), scale});
    write_reg(CFG_VERT_GAIN,   {8'($urandom), g});
    cfg_valid <= 1'b0;
    cur_w     = w;
    cur_h     = h;
    cur_scale = scale;
    settings++;
  endtask

  // Hold off until every transaction has come back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin : ready_driver
    int run, stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          bits;
    int          hmax;
    logic [23:0] s;
    logic [6:0]  gw;
    logic [6:0]  gh;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill the low store region; grids stay inside it so no query touches
    // an unwritten sample
    for (int i = 0; i < FILL_SAMPLES; i++) push_item(load_item(12'(i), 8'($urandom)));

    // directed: default 64x64 grid, unit spacing, corners and edges kept
    // to the loaded rows or to explicitly loaded samples
    push_item(load_item(12'd0, 8'd255));
    push_item(load_item(12'd4095, 8'd0));
    push_item(load_item(12'd1, 8'd0));
    push_item(load_item(12'd64, 8'd128));
    push_item(load_item(12'd2048, 8'd1));
    push_item(query_item(24'd0, 24'd0));
    push_item(query_item(24'd128, 24'd128));
    push_item(query_item(24'd255, 24'd255));
    push_item(query_item(24'd16384, 24'd16384));
    push_item(query_item(24'd16383, 24'd16384));
    push_item(query_item(24'd16128, 24'd600));
    push_item(query_item(24'd16385, 24'd0));
    push_item(query_item(24'd0, 24'd16385));
    push_item(query_item(24'hFFFFFF, 24'd0));
    push_item(query_item(24'd0, 24'hFFFFFF));
    push_item(query_item(24'h800000, 24'h800000));
    push_item(query_item(24'h7FFFFF, 24'h7FFFFF));
    push_item(query_item(24'd16328, 24'd100));

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: program_grid(7'd64, 7'd4, INV_SCALE_RESET, VERT_GAIN_RESET);
        1: program_grid(7'd2, 7'd2, 24'd65536, 24'd0);
        2: program_grid(7'd64, 7'd4, 24'hFFFFFF, 24'hFFFFFF);
        3: program_grid(7'd127, 7'd0, 24'd1, 24'd65536);
        4: program_grid(7'd1, 7'd65, 24'd0, VERT_GAIN_RESET);
        default: begin
          bits = $urandom_range(1, 24);
          s    = 24'($urandom >> (32 - bits));
          if (s == 24'd0) s = 24'd1;
          gw   = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(2, 64));
          hmax = FILL_SAMPLES / side_of(gw);
          if (hmax > 64) hmax = 64;
          gh   = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 1))
                                              : 7'($urandom_range(2, hmax));
          program_grid(gw, gh, s, 24'($urandom));
        end
      endcase
      repeat (76) push_item(random_item());
    end
    drain();

    $display("Covered %0d result transactions, %0d of them in-grid heights, over %0d grid setups",
             checked, hits, settings);
    $display("Low store region loaded up front; edge clamps, out-of-range and register extremes hit.");
    if (fails == 0) begin
      $display("heightmap_bilinear_sampler_top verification clean");
    end else begin
      $display("heightmap_bilinear_sampler_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("heightmap_bilinear_sampler_top verification failed");
    $finish;
  end

endmodule
